// ----- hdl/interrupt_storm_detector_macros.svh -----
// assertion macros used by the checker file
`ifndef INTERRUPT_STORM_DETECTOR_MACROS_SVH
`define INTERRUPT_STORM_DETECTOR_MACROS_SVH

// same-cycle implication, held off during reset
`define ISD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("isd check failed");

// next-cycle implication, held off during reset
`define ISD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("isd check failed");

`endif

// ----- hdl/isd_pkg.sv -----
// ----------------------------------------------------------------------------
// isd_pkg
// Shared types and constants of the interrupt storm detector.
// ----------------------------------------------------------------------------
package isd_pkg;

  localparam int SLOTS    = 32;
  localparam int ADDR_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_W   = 5;
  localparam int IRQ_W    = 32;
  localparam int CNT_W    = 64;
  localparam int THR_W    = 32;
  localparam int ENTRY_W  = IRQ_W + CNT_W;

  localparam logic [THR_W-1:0] THRESH_RESET = 32'd1000000;

  // entry under evaluation
  typedef struct packed {
    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic [IRQ_W-1:0]  irq;
    logic [CNT_W-1:0]  cnt;
    logic              last;
  } item_t;

  // end-of-snapshot report
  typedef struct packed {
    logic             found;
    logic [IRQ_W-1:0] irq;
    logic [CNT_W-1:0] delta;
    logic             base_only;
  } result_t;

endpackage

// ----- hdl/isd_ram.sv -----
// ----------------------------------------------------------------------------
// isd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module isd_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 96,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/isd_eval.sv -----
// ----------------------------------------------------------------------------
// isd_eval
// Compares one entry with its baseline and keeps the per-snapshot latch.
// ----------------------------------------------------------------------------
module isd_eval import isd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  item_t            item_i,
  input  logic [IRQ_W-1:0] base_irq_i,
  input  logic [CNT_W-1:0] base_cnt_i,
  input  logic [THR_W-1:0] threshold_i,
  output result_t          res_o
);

  logic             need_q, need_d;
  logic             found_q, found_d;
  logic [IRQ_W-1:0] found_irq_q, found_irq_d;
  logic [CNT_W-1:0] found_delta_q, found_delta_d;

  logic [CNT_W:0]   diff;
  logic [CNT_W-1:0] delta;
  logic             no_wrap;
  logic             hit;
  logic             storm;
  logic             found_now;
  logic [IRQ_W-1:0] irq_now;
  logic [CNT_W-1:0] delta_now;

  // borrow of the subtract says whether the count went backwards
  assign diff    = {1'b0, item_i.cnt} - {1'b0, base_cnt_i};
  assign delta   = diff[CNT_W-1:0];
  assign no_wrap = ~diff[CNT_W];

  assign hit   = item_i.in_range && !need_q && !found_q &&
                 (item_i.irq == base_irq_i) && no_wrap;
  assign storm = hit && (delta > {{(CNT_W-THR_W){1'b0}}, threshold_i});

  assign found_now = found_q | storm;
  assign irq_now   = storm ? item_i.irq : found_irq_q;
  assign delta_now = storm ? delta : found_delta_q;

  always_comb begin
    need_d        = need_q;
    found_d       = found_now;
    found_irq_d   = irq_now;
    found_delta_d = delta_now;
    res_o         = '0;
    if (need_q) begin
      res_o.base_only = 1'b1;
    end else if (found_now) begin
      res_o.found = 1'b1;
      res_o.irq   = irq_now;
      res_o.delta = delta_now;
    end
    if (item_i.last) begin
      need_d        = need_q ? 1'b0 : found_now;
      found_d       = 1'b0;
      found_irq_d   = '0;
      found_delta_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q  <= 1'b1;
      found_q <= 1'b0;
    end else if (go_i) begin
      need_q  <= need_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      found_irq_q   <= found_irq_d;
      found_delta_q <= found_delta_d;
    end
  end

endmodule

// ----- hdl/interrupt_storm_detector.sv -----
// ----------------------------------------------------------------------------
// interrupt_storm_detector
// Per-slot baseline table with storm detection over successive snapshots.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | sink      | in_valid_i / in_stall_o   | entry_slot, irq_id, irq_count, last_entry
//  out     | source    | out_valid_o / out_stall_i | storm_found, storm_irq, storm_delta,
//          |           |                        | baseline_only
//  cfg     | sink      | cfg_valid_i / cfg_ready_o | storm_threshold
//
// one entry per cycle while no last entry waits: the baseline read is issued as
// a beat is taken, the compare and write-back follow from the registered stage,
// with a bypass when the next entry hits the slot just written. a last entry
// waits in the compare stage while the result register is full and stalled.
// the table has no reset and needs no clearing pass; control state clears at once.
module interrupt_storm_detector import isd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [SLOT_W-1:0] entry_slot_i,
  input  logic [IRQ_W-1:0]  irq_id_i,
  input  logic [CNT_W-1:0]  irq_count_i,
  input  logic              last_entry_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              storm_found_o,
  output logic [IRQ_W-1:0]  storm_irq_o,
  output logic [CNT_W-1:0]  storm_delta_o,
  output logic              baseline_only_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [THR_W-1:0]  cfg_wdata_i
);

  logic [THR_W-1:0]   thr_q;
  logic               s1_valid_q;
  item_t              s1_q;
  logic               fwd_q;
  logic [ENTRY_W-1:0] fwd_data_q;
  logic               out_valid_q;
  result_t            out_q;

  logic               accept;
  logic               go;
  logic               out_free;
  logic               in_range;
  logic               we;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] base;
  result_t            res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign go         = s1_valid_q && (!s1_q.last || out_free);
  assign in_stall_o = s1_valid_q && !go;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = (32'(entry_slot_i) < SLOTS);

  assign we    = go && s1_q.in_range;
  assign wdata = {s1_q.irq, s1_q.cnt};

  isd_ram #(
    .DEPTH (SLOTS),
    .WIDTH (ENTRY_W)
  ) u_table (
    .clk_i   (clk_i),
    .re_i    (accept),
    .raddr_i (ADDR_W'(entry_slot_i)),
    .rdata_o (rdata),
    .we_i    (we),
    .waddr_i (s1_q.addr),
    .wdata_i (wdata)
  );

  // bypass the slot written in the same cycle as its read
  assign base = fwd_q ? fwd_data_q : rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.in_range <= in_range;
      s1_q.addr     <= ADDR_W'(entry_slot_i);
      s1_q.irq      <= irq_id_i;
      s1_q.cnt      <= irq_count_i;
      s1_q.last     <= last_entry_i;
      fwd_q         <= we && (s1_q.addr == ADDR_W'(entry_slot_i));
      fwd_data_q    <= wdata;
    end
  end

  isd_eval u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .item_i      (s1_q),
    .base_irq_i  (base[ENTRY_W-1:CNT_W]),
    .base_cnt_i  (base[CNT_W-1:0]),
    .threshold_i (thr_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go && s1_q.last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && s1_q.last) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign storm_found_o   = out_q.found;
  assign storm_irq_o     = out_q.irq;
  assign storm_delta_o   = out_q.delta;
  assign baseline_only_o = out_q.base_only;

endmodule

// ----- hdl/isd_checker.sv -----
// ----------------------------------------------------------------------------
// isd_checker
// Port-level checks of the storm detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "interrupt_storm_detector_macros.svh"

module isd_checker import isd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              storm_found_o,
  input logic [IRQ_W-1:0]  storm_irq_o,
  input logic [CNT_W-1:0]  storm_delta_o,
  input logic              baseline_only_o
);

  logic                   expect_base_q;
  logic                   out_beat;
  logic                   out_zero;
  logic [IRQ_W+CNT_W+1:0] out_bits;

  assign out_beat = out_valid_o && !out_stall_i;
  assign out_zero = (storm_irq_o == '0) && (storm_delta_o == '0);
  assign out_bits = {storm_found_o, storm_irq_o, storm_delta_o, baseline_only_o};

  // the report after reset or after a storm only sets the baseline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_base_q <= 1'b1;
    end else if (out_beat) begin
      expect_base_q <= storm_found_o;
    end
  end

  `ISD_ASSERT_NOW(a_base_order, clk_i, rst_ni, out_valid_o, baseline_only_o == expect_base_q)

  `ISD_ASSERT_NOW(a_base_quiet, clk_i, rst_ni, out_valid_o && baseline_only_o, !storm_found_o)

  `ISD_ASSERT_NOW(a_none_zero, clk_i, rst_ni, out_valid_o && !storm_found_o, out_zero)

  `ISD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_beat == 1'b0 && out_valid_o, out_valid_o && $stable(out_bits))

endmodule

bind interrupt_storm_detector isd_checker u_isd_checker (.*);

// ----- sim/interrupt_storm_detector_tb.sv -----
// ----------------------------------------------------------------------------
// interrupt_storm_detector_tb
// Self-checking bench for the storm detector. A first snapshot fills every
// slot of the baseline table, a short directed run hits the threshold edges,
// skipped entries and storm latching, then random snapshots follow under
// several thresholds and idle patterns. Each report is checked against a
// behavioural prediction made as the last entry of its snapshot is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interrupt_storm_detector_tb;
  import isd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 600;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [IRQ_W-1:0]  irq;
    logic [CNT_W-1:0]  cnt;
    logic              last;
  } snap_entry_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [SLOT_W-1:0] entry_slot_i = '0;
  logic [IRQ_W-1:0]  irq_id_i = '0;
  logic [CNT_W-1:0]  irq_count_i = '0;
  logic              last_entry_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              storm_found_o;
  logic [IRQ_W-1:0]  storm_irq_o;
  logic [CNT_W-1:0]  storm_delta_o;
  logic              baseline_only_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [THR_W-1:0]  cfg_wdata_i = '0;

  interrupt_storm_detector dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .entry_slot_i    (entry_slot_i),
    .irq_id_i        (irq_id_i),
    .irq_count_i     (irq_count_i),
    .last_entry_i    (last_entry_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .storm_found_o   (storm_found_o),
    .storm_irq_o     (storm_irq_o),
    .storm_delta_o   (storm_delta_o),
    .baseline_only_o (baseline_only_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // prediction state
  logic [THR_W-1:0] threshold_now = THRESH_RESET;
  logic [IRQ_W-1:0] tbl_irq [SLOTS];
  logic [CNT_W-1:0] tbl_cnt [SLOTS];
  logic             awaiting_baseline = 1'b1;
  logic             storm_latched = 1'b0;
  logic [IRQ_W-1:0] latched_irq = '0;
  logic [CNT_W-1:0] latched_delta = '0;
  result_t          expected_reports [$];

  // stimulus state: shadow of what the table will hold once queued entries land
  snap_entry_t      pending_entries [$];
  logic [IRQ_W-1:0] shadow_irq [SLOTS];
  logic [CNT_W-1:0] shadow_cnt [SLOTS];
  logic [THR_W-1:0] gen_threshold = THRESH_RESET;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  logic             hold_req = 1'b0;
  int               held_cycles = 0;
  logic             beat_taken = 1'b0;

  int unsigned entries_queued = 0;
  int unsigned entries_accepted = 0;
  int unsigned reports_checked = 0;
  int unsigned storms_seen = 0;
  int unsigned baselines_seen = 0;
  int unsigned quiet_seen = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned failures = 0;
  int unsigned run_cycles = 0;

  function void log_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  // fold one accepted entry into the detector state, queue a report on a last entry
  function void absorb_entry(input snap_entry_t e);
    logic [CNT_W-1:0] diff;
    result_t          rep;
    if (e.slot < SLOTS) begin
      if (!awaiting_baseline && !storm_latched && e.irq == tbl_irq[e.slot] &&
          e.cnt >= tbl_cnt[e.slot]) begin
        diff = e.cnt - tbl_cnt[e.slot];
        if (diff > {{(CNT_W-THR_W){1'b0}}, threshold_now}) begin
          storm_latched = 1'b1;
          latched_irq   = e.irq;
          latched_delta = diff;
        end
      end
      tbl_irq[e.slot] = e.irq;
      tbl_cnt[e.slot] = e.cnt;
    end
    if (e.last) begin
      rep = '0;
      if (awaiting_baseline) begin
        rep.base_only     = 1'b1;
        awaiting_baseline = 1'b0;
      end else if (storm_latched) begin
        rep.found         = 1'b1;
        rep.irq           = latched_irq;
        rep.delta         = latched_delta;
        awaiting_baseline = 1'b1;
      end
      expected_reports.push_back(rep);
      storm_latched = 1'b0;
      latched_irq   = '0;
      latched_delta = '0;
    end
  endfunction

  function void queue_entry(input logic [SLOT_W-1:0] slot, input logic [IRQ_W-1:0] id,
                            input logic [CNT_W-1:0] cnt, input logic last);
    snap_entry_t e;
    e.slot = slot;
    e.irq  = id;
    e.cnt  = cnt;
    e.last = last;
    pending_entries.push_back(e);
    shadow_irq[slot] = id;
    shadow_cnt[slot] = cnt;
    entries_queued++;
  endfunction

  // mostly well-formed entries that follow the baseline, with some noise
  function void make_random_entry(input logic [SLOT_W-1:0] slot, input logic last);
    int               pick;
    int               sh;
    logic [IRQ_W-1:0] id;
    logic [CNT_W-1:0] cnt;
    pick = $urandom_range(99);
    sh   = $urandom_range(63);
    id   = shadow_irq[slot];
    if (pick < 45)
      cnt = shadow_cnt[slot] + $urandom_range(gen_threshold);
    else if (pick < 50)
      cnt = shadow_cnt[slot] + gen_threshold;
    else if (pick < 56)
      cnt = shadow_cnt[slot] + gen_threshold + 64'd1;
    else if (pick < 62)
      cnt = shadow_cnt[slot] + gen_threshold + 64'd1 + ({$urandom, $urandom} >> sh);
    else if (pick < 72) begin
      id  = shadow_irq[slot] ^ ($urandom | 32'd1);
      cnt = shadow_cnt[slot] + $urandom_range(gen_threshold);
    end else if (pick < 80) begin
      // count going backwards
      if (shadow_cnt[slot] != '0)
        cnt = shadow_cnt[slot] - 64'd1 - ({$urandom, $urandom} % shadow_cnt[slot]);
      else
        cnt = '0;
    end else if (pick < 90) begin
      id  = $urandom;
      cnt = {$urandom, $urandom};
    end else
      cnt = {$urandom, $urandom} >> sh;
    queue_entry(slot, id, cnt, last);
  endfunction

  function void gen_snapshots(input int target, input int max_len);
    int               made;
    int               len;
    logic [SLOT_W-1:0] slot;
    made = 0;
    slot = '0;
    while (made < target) begin
      len = ($urandom_range(19) == 0) ? SLOTS : $urandom_range(max_len, 1);
      for (int i = 0; i < len; i++) begin
        // repeated slot back to back exercises the write-back bypass
        if (len == SLOTS)
          slot = SLOT_W'(i);
        else if (i == 0 || $urandom_range(99) >= 15)
          slot = SLOT_W'($urandom_range(SLOTS - 1));
        make_random_entry(slot, i == len - 1);
        made++;
      end
    end
  endfunction

  task automatic settle();
    wait (entries_accepted == entries_queued && expected_reports.size() == 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    threshold_now = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [THR_W-1:0] thr, input int send_pct,
                           input int stall_pct, input int count, input int max_len,
                           input logic hold);
    settle();
    write_threshold(thr);
    gen_threshold  = thr;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    if (hold) hold_req = 1'b1;
    gen_snapshots(count, max_len);
  endtask

  // input side: offer beats from the pending queue
  always @(negedge clk_i) begin
    snap_entry_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || beat_taken) begin
      if (pending_entries.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_entries.pop_front();
        in_valid_i   <= 1'b1;
        entry_slot_i <= nxt.slot;
        irq_id_i     <= nxt.irq;
        irq_count_i  <= nxt.cnt;
        last_entry_i <= nxt.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    beat_taken = 1'b0;
  end

  always @(posedge clk_i) begin
    snap_entry_t e;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      e.slot = entry_slot_i;
      e.irq  = irq_id_i;
      e.cnt  = irq_count_i;
      e.last = last_entry_i;
      absorb_entry(e);
      entries_accepted++;
      beat_taken = 1'b1;
    end
    if (rst_ni && in_valid_i && in_stall_o) input_stall_cycles++;
  end

  // output side: random stall, plus one long hold-off when requested
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_req && held_cycles < HOLD_CYCLES) begin
      out_stall_i <= 1'b1;
      held_cycles++;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.found     = storm_found_o;
      got.irq       = storm_irq_o;
      got.delta     = storm_delta_o;
      got.base_only = baseline_only_o;
      if (expected_reports.size() == 0) begin
        log_failure($sformatf("unexpected report: found=%0b irq=%h delta=%h base_only=%0b",
                              got.found, got.irq, got.delta, got.base_only));
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        if (got.found !== want.found || got.irq !== want.irq ||
            got.delta !== want.delta || got.base_only !== want.base_only)
          log_failure($sformatf({"report %0d mismatch: expected found=%0b irq=%h delta=%h ",
                                 "base_only=%0b, got found=%0b irq=%h delta=%h base_only=%0b"},
                                reports_checked, want.found, want.irq, want.delta,
                                want.base_only, got.found, got.irq, got.delta, got.base_only));
        if (want.base_only) baselines_seen++;
        else if (want.found) storms_seen++;
        else quiet_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    run_cycles++;
    if (run_cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", run_cycles,
               expected_reports.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // first snapshot writes every slot, so later compares never see an unwritten one
    for (int s = 0; s < SLOTS; s++) begin
      if (s == 0)
        queue_entry(SLOT_W'(s), '0, '0, 1'b0);
      else if (s == SLOTS - 1)
        queue_entry(SLOT_W'(s), '1, '1, 1'b1);
      else
        queue_entry(SLOT_W'(s), $urandom, (({$urandom, $urandom}) >> 16) | 64'd1, 1'b0);
    end

    // reset threshold: equal delta, id change, backwards count, storm, later storm
    queue_entry(2, shadow_irq[2], shadow_cnt[2] + THRESH_RESET, 1'b0);
    queue_entry(3, shadow_irq[3] ^ 32'd1, shadow_cnt[3] + 64'd5000000, 1'b0);
    queue_entry(4, shadow_irq[4], shadow_cnt[4] - 64'd1, 1'b0);
    queue_entry(5, shadow_irq[5], shadow_cnt[5] + THRESH_RESET + 64'd1, 1'b0);
    queue_entry(6, shadow_irq[6], shadow_cnt[6] + 64'd90000000, 1'b1);
    // snapshot after a storm only sets the baseline
    queue_entry(7, shadow_irq[7], shadow_cnt[7] + 64'd50000000, 1'b1);
    queue_entry(7, shadow_irq[7], shadow_cnt[7], 1'b1);
    // wrap from all ones is backwards; full-range delta on irq zero storms
    queue_entry(SLOT_W'(SLOTS - 1), shadow_irq[SLOTS-1], '0, 1'b0);
    queue_entry(0, shadow_irq[0], '1, 1'b1);
    queue_entry(9, shadow_irq[9], shadow_cnt[9] + 64'd1, 1'b1);
    // same slot twice in a row compares against the beat just written
    queue_entry(10, shadow_irq[10], shadow_cnt[10] + 64'd10, 1'b0);
    queue_entry(10, shadow_irq[10], shadow_cnt[10] + THRESH_RESET + 64'd1, 1'b1);
    queue_entry(10, shadow_irq[10], shadow_cnt[10] + 64'd5, 1'b1);
    queue_entry(11, shadow_irq[11], shadow_cnt[11] + THRESH_RESET, 1'b0);
    queue_entry(11, shadow_irq[11], shadow_cnt[11] + 64'd1, 1'b1);

    run_phase(32'd0, 0, 0, 300, 6, 1'b0);
    run_phase(32'hFFFF_FFFF, 87, 0, 300, 6, 1'b0);
    run_phase($urandom, 0, 87, 300, 6, 1'b0);
    run_phase(32'd1000, 20, 20, 300, 6, 1'b0);
    // short snapshots under a long output hold-off fill the pipe
    run_phase($urandom_range(1 << 20), 0, 0, 300, 2, 1'b1);
    run_phase($urandom_range(5000000), 0, 0, 300, 8, 1'b0);

    wait (entries_accepted == entries_queued && expected_reports.size() == 0);
    repeat (16) @(posedge clk_i);
    if (expected_reports.size() != 0)
      log_failure($sformatf("%0d reports never arrived", expected_reports.size()));

    $display("covered %0d entries and %0d reports: %0d storms, %0d baseline-only, %0d quiet",
             entries_accepted, reports_checked, storms_seen, baselines_seen, quiet_seen);
    $display("thresholds zero, max and random; input held back %0d cycles, %0d failures",
             input_stall_cycles, failures);
    if (failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
